// ----- src/stt_pkg.sv -----
`default_nettype none
package stt_pkg;

  localparam int OFFSET_BITS   = 20;
  localparam int KEYWORD_CHARS = 6;
  localparam int PREFIX_BITS   = 8 * KEYWORD_CHARS;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  // token kinds
  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_IDENT  = 6'd1;
  localparam logic [5:0] K_INT    = 6'd2;
  localparam logic [5:0] K_STR    = 6'd3;
  localparam logic [5:0] K_CHR    = 6'd4;
  localparam logic [5:0] K_KW0    = 6'd5;
  localparam logic [5:0] K_INLINE = 6'd12;

  // error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_CHR     = 3'd1;
  localparam logic [2:0] E_STR     = 3'd2;
  localparam logic [2:0] E_INVALID = 3'd3;
  localparam logic [2:0] E_LBRACE  = 3'd4;
  localparam logic [2:0] E_RBRACE  = 3'd5;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_INTEGER, M_IDENT, M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE,
    M_STR, M_STR_ESC, M_OPER, M_INL_SPACE, M_INL_COMMENT, M_INL_BODY
  } mode_t;

  typedef struct packed {
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [2:0]             err;
  } tok_t;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OFFSET_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c ||
           b == 8'h0d;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  // single-character operator kind, 0 when none
  function automatic logic [5:0] single_op(input logic [7:0] c);
    logic [5:0] k;
    k = 6'd0;
    case (c)
      "{": k = 6'd13;
      "}": k = 6'd14;
      "(": k = 6'd15;
      ")": k = 6'd16;
      "[": k = 6'd17;
      "]": k = 6'd18;
      ":": k = 6'd19;
      ",": k = 6'd20;
      "+": k = 6'd21;
      "-": k = 6'd22;
      "*": k = 6'd23;
      "/": k = 6'd24;
      "%": k = 6'd25;
      "!": k = 6'd28;
      "=": k = 6'd29;
      "<": k = 6'd32;
      ">": k = 6'd33;
      "&": k = 6'd38;
      "|": k = 6'd39;
      "@": k = 6'd40;
      "~": k = 6'd41;
      "^": k = 6'd42;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  // two-character operator kind, 0 when none
  function automatic logic [5:0] pair_op(input logic [7:0] c, input logic [7:0] d);
    logic [5:0] k;
    k = 6'd0;
    case ({c, d})
      {"&", "&"}: k = 6'd26;
      {"|", "|"}: k = 6'd27;
      {"=", "="}: k = 6'd30;
      {"!", "="}: k = 6'd31;
      {"<", "="}: k = 6'd34;
      {">", "="}: k = 6'd35;
      {"<", "<"}: k = 6'd36;
      {">", ">"}: k = 6'd37;
      default:    k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic [PREFIX_BITS-1:0] pack_kw(input logic [63:0] s);
    return s[PREFIX_BITS-1:0];
  endfunction

  // keyword lookup on length and prefix
  function automatic logic [5:0] name_kind(input logic [OFFSET_BITS-1:0] len,
                                           input logic [PREFIX_BITS-1:0] p);
    logic [5:0] k;
    k = K_IDENT;
    if (len == 2 && p == pack_kw(64'h6669)) k = 6'd5;
    else if (len == 4 && p == pack_kw(64'h65736c65)) k = 6'd6;
    else if (len == 5 && p == pack_kw(64'h656c696877)) k = 6'd7;
    else if (len == 5 && p == pack_kw(64'h6b61657262)) k = 6'd8;
    else if (len == 3 && p == pack_kw(64'h6e7566)) k = 6'd9;
    else if (len == 6 && p == pack_kw(64'h6e7275746572)) k = 6'd10;
    else if (len == 6 && p == pack_kw(64'h6e7265747865)) k = 6'd11;
    else if (len == 6 && p == pack_kw(64'h656e696c6e69)) k = K_INLINE;
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- src/source_text_tokenizer.sv -----
`default_nettype none
// Streaming tokenizer: one source byte or end-of-input request is taken every
// clock while in_stall is low, and each request yields zero, one or two tokens
// (kind, body offset, body length, error code, last). The lexer state advances
// on each accepted request and its results appear on the output the cycle after
// acceptance, through a two-entry output queue. in_stall rises while the queue
// holds two results, or holds one that the receiver is stalling; a request is
// taken in the same cycle that the last queued result leaves, so with no receiver
// stall a request is held back only after one that gave two results. Errors halt
// the lexer until end of input, which flushes, emits an end token and resets state.
module source_text_tokenizer (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [0:0]                     in_command,
  input  wire  [7:0]                     in_char_byte,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [5:0]                     out_token_kind,
  output logic [stt_pkg::OFFSET_BITS-1:0] out_start_offset,
  output logic [stt_pkg::OFFSET_BITS-1:0] out_token_length,
  output logic [2:0]                     out_error_code,
  output logic                           out_last
);
  import stt_pkg::*;

  localparam int QW = $bits(tok_t) + 1;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [OFFSET_BITS-1:0] tlen_r, tlen_nxt;
  logic [PREFIX_BITS-1:0] prefix_r, prefix_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic                   halted_r, halted_nxt;

  tok_t       res0, res1;
  logic [1:0] nres;

  // output queue
  logic [QW-1:0] q_r [2];
  logic [1:0]    cnt_r;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (cnt_r == 2'd2) || (cnt_r == 2'd1 && out_stall);
  assign out_valid = (cnt_r != 2'd0);
  assign {out_token_kind, out_start_offset, out_token_length, out_error_code, out_last} = q_r[0];

  // lexer next-state logic
  always_comb begin
    logic [7:0]  b;
    logic        restart;
    logic        do_inl;
    logic [5:0]  kk;
    tok_t        t;
    b = in_char_byte;
    restart = 1'b0;
    do_inl  = 1'b0;
    kk      = 6'd0;
    t       = '0;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    prefix_nxt = prefix_r;
    pend_nxt   = pend_r;
    halted_nxt = halted_r;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;

    if (in_command[0]) begin
      // end of input: flush then end token
      if (!halted_r) begin
        case (mode_r)
          M_INTEGER: begin
            res0 = '{K_INT, tstart_r, tlen_r, E_NONE}; nres = 2'd1;
          end
          M_IDENT: begin
            kk = name_kind(tlen_r, prefix_r);
            if (kk == K_INLINE) res0 = '{K_END, pos_r, '0, E_LBRACE};
            else res0 = '{kk, tstart_r, tlen_r, E_NONE};
            nres = 2'd1;
          end
          M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE: begin
            res0 = '{K_END, pos_r, '0, E_CHR}; nres = 2'd1;
          end
          M_STR, M_STR_ESC: begin
            res0 = '{K_END, pos_r, '0, E_STR}; nres = 2'd1;
          end
          M_OPER: begin
            res0 = '{single_op(pend_r), tstart_r, OFFSET_BITS'(1), E_NONE}; nres = 2'd1;
          end
          M_INL_SPACE, M_INL_COMMENT: begin
            res0 = '{K_END, pos_r, '0, E_LBRACE}; nres = 2'd1;
          end
          M_INL_BODY: begin
            res0 = '{K_END, pos_r, '0, E_RBRACE}; nres = 2'd1;
          end
          default: nres = 2'd0;
        endcase
      end
      t = '{K_END, pos_r, '0, E_NONE};
      if (nres == 2'd0) res0 = t;
      else res1 = t;
      nres = nres + 2'd1;
      mode_nxt = M_IDLE; pos_nxt = '0; tstart_nxt = '0; tlen_nxt = '0;
      prefix_nxt = '0; pend_nxt = '0; halted_nxt = 1'b0;
    end else begin
      pos_nxt = sat_inc(pos_r);
      if (!halted_r) begin
        case (mode_r)
          M_COMMENT: if (b == 8'h0a) mode_nxt = M_IDLE;
          M_INL_COMMENT: if (b == 8'h0a) mode_nxt = M_INL_SPACE;
          M_INTEGER: begin
            if (is_digit(b)) tlen_nxt = sat_inc(tlen_r);
            else begin
              res0 = '{K_INT, tstart_r, tlen_r, E_NONE}; nres = 2'd1;
              restart = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(b) || is_digit(b) || b == "_") begin
              for (int i = 1; i < KEYWORD_CHARS; i++)
                if (tlen_r == OFFSET_BITS'(i)) prefix_nxt[8*i +: 8] = b;
              tlen_nxt = sat_inc(tlen_r);
            end else begin
              kk = name_kind(tlen_r, prefix_r);
              if (kk == K_INLINE) do_inl = 1'b1;
              else begin
                res0 = '{kk, tstart_r, tlen_r, E_NONE}; nres = 2'd1;
                restart = 1'b1;
              end
            end
          end
          M_CHR_OPEN: begin
            tlen_nxt = OFFSET_BITS'(1);
            mode_nxt = (b == 8'h5c) ? M_CHR_ESC : M_CHR_CLOSE;
          end
          M_CHR_ESC: begin
            tlen_nxt = OFFSET_BITS'(2);
            mode_nxt = M_CHR_CLOSE;
          end
          M_CHR_CLOSE: begin
            if (b == 8'h27) res0 = '{K_CHR, tstart_r, tlen_r, E_NONE};
            else begin
              res0 = '{K_END, pos_r, '0, E_CHR}; halted_nxt = 1'b1;
            end
            nres = 2'd1; mode_nxt = M_IDLE;
          end
          M_STR: begin
            if (b == 8'h22) begin
              res0 = '{K_STR, tstart_r, tlen_r, E_NONE}; nres = 2'd1; mode_nxt = M_IDLE;
            end else begin
              if (b == 8'h5c) mode_nxt = M_STR_ESC;
              tlen_nxt = sat_inc(tlen_r);
            end
          end
          M_STR_ESC: begin
            tlen_nxt = sat_inc(tlen_r); mode_nxt = M_STR;
          end
          M_OPER: begin
            kk = pair_op(pend_r, b);
            if (kk != 6'd0) begin
              res0 = '{kk, tstart_r, OFFSET_BITS'(2), E_NONE}; mode_nxt = M_IDLE;
            end else begin
              res0 = '{single_op(pend_r), tstart_r, OFFSET_BITS'(1), E_NONE};
              restart = 1'b1;
            end
            nres = 2'd1;
          end
          M_INL_SPACE: do_inl = 1'b1;
          M_INL_BODY: begin
            if (b == "}") begin
              res0 = '{K_INLINE, tstart_r, tlen_r, E_NONE}; nres = 2'd1; mode_nxt = M_IDLE;
            end else tlen_nxt = sat_inc(tlen_r);
          end
          default: restart = 1'b1;
        endcase

        // whitespace, comments and the opening brace before the inline body
        if (do_inl) begin
          mode_nxt = M_INL_SPACE;
          if (is_space(b)) mode_nxt = M_INL_SPACE;
          else if (b == "#") mode_nxt = M_INL_COMMENT;
          else if (b == "{") begin
            mode_nxt = M_INL_BODY; tstart_nxt = sat_inc(pos_r); tlen_nxt = '0;
          end else begin
            res0 = '{K_END, pos_r, '0, E_LBRACE}; nres = 2'd1;
            halted_nxt = 1'b1; mode_nxt = M_IDLE;
          end
        end

        // start of a new token
        if (restart) begin
          mode_nxt = M_IDLE;
          tlen_nxt = '0;
          t = '{K_END, pos_r, '0, E_INVALID};
          if (is_space(b)) mode_nxt = M_IDLE;
          else if (b == "#") mode_nxt = M_COMMENT;
          else if (is_digit(b)) begin
            mode_nxt = M_INTEGER; tstart_nxt = pos_r; tlen_nxt = OFFSET_BITS'(1);
          end else if (is_alpha(b) || b == "_") begin
            mode_nxt = M_IDENT; tstart_nxt = pos_r; tlen_nxt = OFFSET_BITS'(1);
            prefix_nxt = {{(PREFIX_BITS-8){1'b0}}, b};
          end else if (b == 8'h27) begin
            mode_nxt = M_CHR_OPEN; tstart_nxt = sat_inc(pos_r);
          end else if (b == 8'h22) begin
            mode_nxt = M_STR; tstart_nxt = sat_inc(pos_r);
          end else if (single_op(b) != 6'd0) begin
            mode_nxt = M_OPER; pend_nxt = b; tstart_nxt = pos_r;
          end else begin
            halted_nxt = 1'b1;
            if (nres == 2'd0) res0 = t;
            else res1 = t;
            nres = nres + 2'd1;
          end
        end
      end
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pos_r <= '0; tstart_r <= '0; tlen_r <= '0;
      prefix_r <= '0; pend_r <= '0; halted_r <= 1'b0;
    end else if (in_acc) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; tstart_r <= tstart_nxt;
      tlen_r <= tlen_nxt; prefix_r <= prefix_nxt; pend_r <= pend_nxt;
      halted_r <= halted_nxt;
    end
  end

  // result queue: filled when empty or when its last entry leaves, drained one
  // entry per accepted output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= nres;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r[0] <= {res0, nres == 2'd1};
      q_r[1] <= {res1, 1'b1};
    end else if (out_acc) begin
      q_r[0] <= q_r[1];
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result count out of range");
  a_halt_nores: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && halted_r && !in_command[0]) |=> cnt_r == 2'd0)
    else $error("halted lexer produced a result");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_command[0]) |=> (cnt_r != 2'd0))
    else $error("end of input gave no result");
`endif

endmodule
`default_nettype wire
